>>> design/modbus_read_registers_responder_core_defines.svh
// Assertion macros shared by the responder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef MODBUS_READ_REGISTERS_RESPONDER_CORE_DEFINES_SVH
`define MODBUS_READ_REGISTERS_RESPONDER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define MRR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MRR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define MRR_ASSERT(lbl, prop, msg)
`define MRR_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

>>> design/mrr_pkg.sv
// Types, constants and helper functions of the Modbus read-registers responder.
// No dependencies; imported by every module of the block.
package mrr_pkg;

    localparam int CHANNELS_DEF  = 7;
    localparam int MAX_FRAME_DEF = 256;
    localparam int OFS_W = 6;
    localparam int CNT_W = 7;

    localparam logic [7:0]  SLAVE_RST = 8'd1;
    localparam logic [15:0] FIRST_RST = 16'd30001;
    localparam logic [6:0]  MAXC_RST  = 7'd125;

    localparam logic [1:0] CFG_SLAVE = 2'd0;
    localparam logic [1:0] CFG_FIRST = 2'd1;
    localparam logic [1:0] CFG_MAXC  = 2'd2;

    localparam logic [7:0] FUNC_READ = 8'h03;
    localparam logic [7:0] EXC_FLAG  = 8'h80;
    localparam logic [1:0] EXC_FUNC  = 2'd1;
    localparam logic [1:0] EXC_ADDR  = 2'd2;
    localparam logic [1:0] EXC_COUNT = 2'd3;

    localparam logic [3:0] IPD_LEN    = 4'd7;
    localparam logic [3:0] CLOSED_LEN = 4'd6;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [10:0] LEN_SAT = 11'd2047;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
        logic       start_of_message;
        logic [2:0] sample_channel;
        logic [7:0] sample_value;
    } request_t;

    typedef struct packed {
        logic       event_kind;
        logic [7:0] tx_byte;
        logic       last_byte;
    } result_t;

    typedef enum logic [2:0] {
        PH_IDLE, PH_IPD, PH_CLOSED, PH_LEN, PH_FRAME
    } phase_t;

    typedef enum logic [1:0] {
        JOB_CLOSED, JOB_EXC, JOB_READ
    } job_kind_t;

    typedef struct packed {
        job_kind_t        kind;
        logic [7:0]       func;
        logic [1:0]       code;
        logic [OFS_W-1:0] offset;
        logic [CNT_W-1:0] count;
    } job_t;

    localparam int JOB_W = $bits(job_t);

    function automatic logic [7:0] ipd_char(input logic [3:0] idx);
        case (idx)
            4'd0:    ipd_char = 8'h0D;
            4'd1:    ipd_char = 8'h0A;
            4'd2:    ipd_char = 8'h2B;
            4'd3:    ipd_char = 8'h49;
            4'd4:    ipd_char = 8'h50;
            4'd5:    ipd_char = 8'h44;
            4'd6:    ipd_char = 8'h2C;
            default: ipd_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] closed_char(input logic [3:0] idx);
        case (idx)
            4'd0:    closed_char = 8'h43;
            4'd1:    closed_char = 8'h4C;
            4'd2:    closed_char = 8'h4F;
            4'd3:    closed_char = 8'h53;
            4'd4:    closed_char = 8'h45;
            4'd5:    closed_char = 8'h44;
            default: closed_char = 8'h00;
        endcase
    endfunction

    // CRC-16/MODBUS, reflected poly 0xA001, one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        crc_feed = c;
    endfunction

endpackage

>>> design/mrr_job_fifo.sv
// Short job queue between the parser front and the response back end.
// Depends on mrr_pkg and the assertion macro header.
`include "modbus_read_registers_responder_core_defines.svh"
module mrr_job_fifo
    import mrr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0]      cnt_reg, cnt_next;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
        end
        if (pop)
        begin
            rp_next = (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    `MRR_ASSERT(a_cnt_range, cnt_reg <= (AW+1)'(DEPTH), "job queue count out of range")
    `MRR_ASSERT_IMPL(a_no_overflow, push, !full || pop, "job pushed into full queue")
    `MRR_ASSERT_IMPL(a_no_underflow, pop, !empty, "job popped from empty queue")

endmodule

>>> design/mrr_front.sv
// Parser front: header match, length decode, frame capture, CRC check, job issue.
// Depends on mrr_pkg.
module mrr_front
    import mrr_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  request_t              req,
    input  logic [7:0]            slave_address,
    input  logic [15:0]           first_register,
    input  logic [6:0]            max_count,
    output logic                  job_push,
    output job_t                  job,
    output logic [CHANNELS*8-1:0] snap
);
    phase_t      phase_reg, phase_next;
    logic [3:0]  hp_reg, hp_next;
    logic [10:0] len_reg, len_next;
    logic [10:0] idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  unit_reg, unit_next;
    logic [7:0]  func_reg, func_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  trail_reg, trail_next;
    logic [CHANNELS*8-1:0] samp_reg, samp_next;

    logic [7:0]  b;
    logic [14:0] acc;
    logic [15:0] ofs;
    logic [16:0] span;

    assign b    = req.rx_byte;
    assign snap = samp_reg;
    assign acc  = {4'd0, len_reg} * 15'd10 + {7'd0, b - CH_ZERO};
    assign ofs  = start_reg - first_register;
    assign span = {1'b0, ofs} + {1'b0, count_reg};

    always_comb
    begin
        phase_next = phase_reg;
        hp_next    = hp_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        unit_next  = unit_reg;
        func_next  = func_reg;
        start_next = start_reg;
        count_next = count_reg;
        trail_next = trail_reg;
        samp_next  = samp_reg;
        job_push   = 1'b0;
        job.kind   = JOB_CLOSED;
        job.func   = func_reg;
        job.code   = EXC_FUNC;
        job.offset = ofs[OFS_W-1:0];
        job.count  = count_reg[CNT_W-1:0];

        if (fire && req.command)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if ({4'd0, req.sample_channel} == 7'(i))
                begin
                    samp_next[i*8 +: 8] = req.sample_value;
                end
            end
        end
        else if (fire && req.start_of_message)
        begin
            hp_next = 4'd1;
            if (b == CH_CR)
            begin
                phase_next = PH_IPD;
            end
            else if (b == CH_C)
            begin
                phase_next = PH_CLOSED;
            end
            else
            begin
                phase_next = PH_IDLE;
            end
        end
        else if (fire)
        begin
            case (phase_reg)
                PH_IPD:
                begin
                    if (hp_reg < IPD_LEN && b == ipd_char(hp_reg))
                    begin
                        hp_next = hp_reg + 1'b1;
                        if (hp_next == IPD_LEN)
                        begin
                            phase_next = PH_LEN;
                            len_next   = '0;
                        end
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_CLOSED:
                begin
                    if (hp_reg < CLOSED_LEN && b == closed_char(hp_reg))
                    begin
                        hp_next = hp_reg + 1'b1;
                        if (hp_next == CLOSED_LEN)
                        begin
                            phase_next = PH_IDLE;
                            job_push   = 1'b1;
                            job.kind   = JOB_CLOSED;
                        end
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_LEN:
                begin
                    if (b >= CH_ZERO && b <= CH_NINE)
                    begin
                        len_next = (acc > {4'd0, LEN_SAT}) ? LEN_SAT : acc[10:0];
                    end
                    else if (b == CH_COLON && len_reg >= 11'd4 &&
                             {1'b0, len_reg} <= 12'(MAX_FRAME))
                    begin
                        phase_next = PH_FRAME;
                        idx_next   = '0;
                        crc_next   = 16'hFFFF;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_FRAME:
                begin
                    if (idx_reg < len_reg - 11'd2)
                    begin
                        crc_next = crc_feed(crc_reg, b);
                    end
                    case (idx_reg)
                        11'd0:   unit_next = b;
                        11'd1:   func_next = b;
                        11'd2:   start_next = {b, start_reg[7:0]};
                        11'd3:   start_next = {start_reg[15:8], b};
                        11'd4:   count_next = {b, count_reg[7:0]};
                        11'd5:   count_next = {count_reg[15:8], b};
                        default: ;
                    endcase
                    if (idx_reg == len_reg - 11'd2)
                    begin
                        trail_next = b;
                    end
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == len_reg - 11'd1)
                    begin
                        phase_next = PH_IDLE;
                        if ({b, trail_reg} == crc_reg && unit_reg == slave_address)
                        begin
                            if (func_reg != FUNC_READ)
                            begin
                                job_push = 1'b1;
                                job.kind = JOB_EXC;
                                job.code = EXC_FUNC;
                            end
                            else if (len_reg >= 11'd8)
                            begin
                                job_push = 1'b1;
                                if (count_reg == '0 || count_reg > {9'd0, max_count})
                                begin
                                    job.kind = JOB_EXC;
                                    job.code = EXC_COUNT;
                                end
                                else if (start_reg < first_register ||
                                         span > 17'(CHANNELS))
                                begin
                                    job.kind = JOB_EXC;
                                    job.code = EXC_ADDR;
                                end
                                else
                                begin
                                    job.kind = JOB_READ;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            hp_reg    <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            crc_reg   <= 16'hFFFF;
            unit_reg  <= '0;
            func_reg  <= '0;
            start_reg <= '0;
            count_reg <= '0;
            trail_reg <= '0;
            samp_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hp_reg    <= hp_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            crc_reg   <= crc_next;
            unit_reg  <= unit_next;
            func_reg  <= func_next;
            start_reg <= start_next;
            count_reg <= count_next;
            trail_reg <= trail_next;
            samp_reg  <= samp_next;
        end
    end

endmodule

>>> design/mrr_back.sv
// Response back end: walks one job byte by byte, appends CRC, feeds the output register.
// Depends on mrr_pkg and the assertion macro header.
`include "modbus_read_registers_responder_core_defines.svh"
module mrr_back
    import mrr_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_empty,
    input  job_t                  job,
    input  logic [CHANNELS*8-1:0] snap,
    output logic                  job_pop,
    input  logic [7:0]            slave_address,
    output logic                  empty,
    input  logic                  pop,
    output result_t               result
);
    logic [7:0]  k_reg, k_next;
    logic [15:0] crc_reg, crc_next;
    logic        ov_reg, ov_next;
    result_t     out_reg, out_next;

    logic        advance;
    logic [7:0]  last_k, dk, byte_v, samp;
    logic [6:0]  ch;
    logic        is_last;

    assign empty   = !ov_reg;
    assign result  = out_reg;
    assign advance = !job_empty && (!ov_reg || pop);
    assign dk      = k_reg - 8'd3;
    assign ch      = {1'b0, job.offset} + dk[7:1];

    always_comb
    begin
        case (job.kind)
            JOB_CLOSED: last_k = 8'd0;
            JOB_EXC:    last_k = 8'd4;
            default:    last_k = 8'd4 + {job.count, 1'b0};
        endcase
    end

    always_comb
    begin
        samp = 8'h00;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (ch == 7'(i))
            begin
                samp = snap[i*8 +: 8];
            end
        end
    end

    always_comb
    begin
        is_last  = (k_reg == last_k);
        crc_next = crc_reg;
        byte_v   = 8'h00;
        if (job.kind == JOB_CLOSED)
        begin
            byte_v = 8'h00;
        end
        else if (is_last)
        begin
            byte_v = crc_reg[15:8];
        end
        else if (k_reg == last_k - 8'd1)
        begin
            byte_v = crc_reg[7:0];
        end
        else
        begin
            case (k_reg)
                8'd0:    byte_v = slave_address;
                8'd1:    byte_v = (job.kind == JOB_READ) ? FUNC_READ : (job.func | EXC_FLAG);
                8'd2:    byte_v = (job.kind == JOB_READ) ? {job.count, 1'b0} :
                                  {6'd0, job.code};
                default: byte_v = dk[0] ? samp : 8'h00;
            endcase
            crc_next = crc_feed(crc_reg, byte_v);
        end

        k_next   = k_reg;
        ov_next  = ov_reg;
        out_next = out_reg;
        job_pop  = 1'b0;
        if (advance)
        begin
            ov_next             = 1'b1;
            out_next.event_kind = (job.kind == JOB_CLOSED);
            out_next.tx_byte    = byte_v;
            out_next.last_byte  = is_last;
            if (is_last)
            begin
                k_next   = '0;
                crc_next = 16'hFFFF;
                job_pop  = 1'b1;
            end
            else
            begin
                k_next = k_reg + 1'b1;
            end
        end
        else
        begin
            crc_next = crc_reg;
            if (pop)
            begin
                ov_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg   <= '0;
            crc_reg <= 16'hFFFF;
            ov_reg  <= 1'b0;
        end
        else
        begin
            k_reg   <= k_next;
            crc_reg <= crc_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    `MRR_ASSERT_IMPL(a_closed_last, ov_reg && out_reg.event_kind, out_reg.last_byte,
        "closed notice not marked last")
    `MRR_ASSERT_IMPL(a_pop_on_last, job_pop, advance && is_last, "job retired early")
    `MRR_ASSERT_IMPL(a_idle_k, job_empty, k_reg == '0, "byte index left mid-job")

endmodule

>>> design/modbus_read_registers_responder_core.sv
// Top level of the Modbus RTU read-holding-registers responder.
// Depends on mrr_pkg, mrr_front, mrr_job_fifo and mrr_back.
//
// Usage:
//  - Input queue side: drive request and push; an item is taken on a clock
//    edge with push high and full low. Items are modem bytes or sample updates.
//  - Result side: while empty is low the oldest result sits on result; pop
//    high on a clock edge takes it.
//  - Config: cfg_valid/cfg_ready with cfg_index (0 slave address, 1 first
//    register, 2 max count) and cfg_data; ready is always high. Write only
//    while the block is idle.
//  - The last frame byte is classified in its accept cycle; its job is queued,
//    then walked into the output register. Responses stream one item per cycle
//    while pop is high (5 items for an exception, 5 + 2*count for a read,
//    1 for CLOSED). Input items are taken one per cycle while full is low;
//    full rises only when the two-entry job queue holds two pending responses.
//  - A stalled result side stops the byte walker; the parser keeps taking
//    items until the job queue fills.
//  - Reset clears parse state, channel samples and config to defaults.
module modbus_read_registers_responder_core
    import mrr_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  request_t    request,
    input  logic        push,
    output logic        full,
    output result_t     result,
    output logic        empty,
    input  logic        pop,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int QW = JOB_W + CHANNELS*8;

    logic [7:0]  slave_reg;
    logic [15:0] first_reg;
    logic [6:0]  maxc_reg;

    logic                  fire, jpush, jpop, jfull, jempty;
    job_t                  fjob, bjob;
    logic [CHANNELS*8-1:0] fsnap, bsnap;
    logic [QW-1:0]         qrd;

    assign cfg_ready = 1'b1;
    assign full      = jfull;
    assign fire      = push && !jfull;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_reg <= SLAVE_RST;
            first_reg <= FIRST_RST;
            maxc_reg  <= MAXC_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SLAVE: slave_reg <= cfg_data[7:0];
                CFG_FIRST: first_reg <= cfg_data;
                CFG_MAXC:  maxc_reg  <= cfg_data[6:0];
                default:   ;
            endcase
        end
    end

    mrr_front #(.CHANNELS(CHANNELS), .MAX_FRAME(MAX_FRAME)) u_front (
        .clk(clk), .rst_n(rst_n), .fire(fire), .req(request),
        .slave_address(slave_reg), .first_register(first_reg), .max_count(maxc_reg),
        .job_push(jpush), .job(fjob), .snap(fsnap)
    );

    mrr_job_fifo #(.WIDTH(QW), .DEPTH(2)) u_fifo (
        .clk(clk), .rst_n(rst_n), .push(jpush), .wdata({fsnap, fjob}), .full(jfull),
        .pop(jpop), .rdata(qrd), .empty(jempty)
    );

    assign bjob  = job_t'(qrd[JOB_W-1:0]);
    assign bsnap = qrd[QW-1:JOB_W];

    mrr_back #(.CHANNELS(CHANNELS)) u_back (
        .clk(clk), .rst_n(rst_n), .job_empty(jempty), .job(bjob), .snap(bsnap),
        .job_pop(jpop), .slave_address(slave_reg), .empty(empty), .pop(pop),
        .result(result)
    );

endmodule

>>> dv/modbus_read_registers_responder_core_tb.sv
// Self-checking bench for the Modbus read-registers responder core.
// Depends on mrr_pkg and modbus_read_registers_responder_core; predicts
// every response byte and checks it against the result queue.
module modbus_read_registers_responder_core_tb;
    import mrr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CH_N      = CHANNELS_DEF;
    localparam int FRAME_MAX = MAX_FRAME_DEF;
    localparam int WDOG_MAX  = 5000;

    logic        clk;
    logic        rst_n;
    request_t    request;
    logic        push;
    logic        full;
    result_t     result;
    logic        empty;
    logic        pop;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    modbus_read_registers_responder_core DUT (
        .clk(clk), .rst_n(rst_n), .request(request), .push(push), .full(full),
        .result(result), .empty(empty), .pop(pop), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [7:0]  unit_addr;
    logic [15:0] base_reg;
    logic [6:0]  count_limit;
    logic [3:0]  hdr_pos;
    phase_t      phase;
    logic [10:0] decl_len;
    logic [10:0] byte_pos;
    logic [15:0] crc_acc;
    logic [7:0]  f_unit;
    logic [7:0]  f_func;
    logic [15:0] f_start;
    logic [15:0] f_count;
    logic [15:0] rx_crc;
    logic [7:0]  samples [CH_N];

    request_t pending_items [$];
    result_t  expected_bytes [$];

    int  sender_idle;
    int  receiver_idle;
    bit  failed;
    bit  stim_done;
    int  wdog;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] c_in,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] ipd_byte(input int k);
        logic [7:0] p [7];
        p = '{8'h0D, 8'h0A, 8'h2B, 8'h49, 8'h50, 8'h44, 8'h2C};
        return (k < 7) ? p[k] : 8'h00;
    endfunction

    function automatic logic [7:0] closed_byte(input int k);
        logic [7:0] p [6];
        p = '{8'h43, 8'h4C, 8'h4F, 8'h53, 8'h45, 8'h44};
        return (k < 6) ? p[k] : 8'h00;
    endfunction

    // queues a response frame, appending its CRC low byte first
    task automatic queue_response(input logic [7:0] body [$]);
        logic [15:0] c;
        result_t r;
        c = 16'hFFFF;
        foreach (body[i])
            c = crc16_step(c, body[i]);
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        foreach (body[i])
        begin
            r.event_kind = 1'b0;
            r.tx_byte = body[i];
            r.last_byte = (i == body.size() - 1);
            expected_bytes.push_back(r);
        end
    endtask

    task automatic queue_exception(input logic [1:0] code);
        logic [7:0] body [$];
        body = '{unit_addr, f_func | EXC_FLAG, {6'd0, code}};
        queue_response(body);
    endtask

    task automatic close_frame();
        logic [7:0]  body [$];
        logic [16:0] ofs;
        if (rx_crc != crc_acc || f_unit != unit_addr)
            return;
        if (f_func != FUNC_READ)
        begin
            queue_exception(EXC_FUNC);
            return;
        end
        if (decl_len < 8)
            return;
        if (f_count == 0 || f_count > {9'd0, count_limit})
        begin
            queue_exception(EXC_COUNT);
            return;
        end
        if (f_start < base_reg)
        begin
            queue_exception(EXC_ADDR);
            return;
        end
        ofs = f_start - base_reg;
        if (ofs + f_count > CH_N)
        begin
            queue_exception(EXC_ADDR);
            return;
        end
        body = '{unit_addr, FUNC_READ, f_count[6:0] * 8'd2};
        for (int i = 0; i < f_count; i++)
        begin
            body.push_back(8'h00);
            body.push_back(samples[ofs + i]);
        end
        queue_response(body);
    endtask

    // advances the parser model by one accepted item
    task automatic model_item(input request_t it);
        logic [7:0]  b;
        logic [10:0] i;
        int v;
        result_t r;
        b = it.rx_byte;
        if (it.command)
        begin
            if (it.sample_channel < CH_N)
                samples[it.sample_channel] = it.sample_value;
            return;
        end
        if (it.start_of_message)
        begin
            hdr_pos = 4'd1;
            phase = (b == CH_CR) ? PH_IPD : (b == CH_C) ? PH_CLOSED : PH_IDLE;
            return;
        end
        case (phase)
            PH_IPD:
            begin
                if (hdr_pos < IPD_LEN && b == ipd_byte(hdr_pos))
                begin
                    hdr_pos++;
                    if (hdr_pos == IPD_LEN)
                    begin
                        phase = PH_LEN;
                        decl_len = '0;
                    end
                end
                else
                    phase = PH_IDLE;
            end
            PH_CLOSED:
            begin
                if (hdr_pos < CLOSED_LEN && b == closed_byte(hdr_pos))
                begin
                    hdr_pos++;
                    if (hdr_pos == CLOSED_LEN)
                    begin
                        phase = PH_IDLE;
                        r.event_kind = 1'b1;
                        r.tx_byte = 8'h00;
                        r.last_byte = 1'b1;
                        expected_bytes.push_back(r);
                    end
                end
                else
                    phase = PH_IDLE;
            end
            PH_LEN:
            begin
                if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    v = decl_len * 10 + (b - CH_ZERO);
                    decl_len = (v > LEN_SAT) ? LEN_SAT : v[10:0];
                end
                else if (b == CH_COLON && decl_len >= 4 && decl_len <= FRAME_MAX)
                begin
                    phase = PH_FRAME;
                    byte_pos = '0;
                    crc_acc = 16'hFFFF;
                end
                else
                    phase = PH_IDLE;
            end
            PH_FRAME:
            begin
                i = byte_pos;
                if (i + 2 < decl_len)
                    crc_acc = crc16_step(crc_acc, b);
                case (i)
                    0: f_unit = b;
                    1: f_func = b;
                    2: f_start[15:8] = b;
                    3: f_start[7:0] = b;
                    4: f_count[15:8] = b;
                    5: f_count[7:0] = b;
                    default: ;
                endcase
                if (i == decl_len - 2)
                    rx_crc[7:0] = b;
                byte_pos = i + 1;
                if (i == decl_len - 1)
                begin
                    rx_crc[15:8] = b;
                    phase = PH_IDLE;
                    close_frame();
                end
            end
            default: ;
        endcase
    endtask

    // ---------------- stimulus builders ----------------
    function automatic request_t msg_byte(input logic [7:0] b, input bit first);
        request_t it;
        it = '0;
        it.rx_byte = b;
        it.start_of_message = first;
        it.sample_channel = $urandom_range(0, 7);
        it.sample_value = $urandom;
        return it;
    endfunction

    task automatic add_sample(input logic [2:0] ch, input logic [7:0] val);
        request_t it;
        it = '0;
        it.command = 1'b1;
        it.rx_byte = $urandom;
        it.start_of_message = $urandom_range(0, 1);
        it.sample_channel = ch;
        it.sample_value = val;
        pending_items.push_back(it);
    endtask

    task automatic add_closed();
        for (int k = 0; k < 6; k++)
            pending_items.push_back(msg_byte(closed_byte(k), k == 0));
    endtask

    // sends "\r\n+IPD,<len>:" then the frame; good_crc appends a valid CRC
    task automatic add_frame(input logic [7:0] fb [$], input bit good_crc);
        logic [15:0] c;
        string s;
        if (good_crc)
        begin
            c = 16'hFFFF;
            foreach (fb[i])
                c = crc16_step(c, fb[i]);
            fb.push_back(c[7:0]);
            fb.push_back(c[15:8]);
        end
        for (int k = 0; k < 7; k++)
            pending_items.push_back(msg_byte(ipd_byte(k), k == 0));
        s = $sformatf("%0d", fb.size());
        for (int k = 0; k < s.len(); k++)
            pending_items.push_back(msg_byte(s[k], 1'b0));
        pending_items.push_back(msg_byte(CH_COLON, 1'b0));
        foreach (fb[i])
            pending_items.push_back(msg_byte(fb[i], 1'b0));
    endtask

    task automatic add_read(input logic [7:0] u, input logic [15:0] st,
                            input logic [15:0] cnt, input bit good_crc);
        logic [7:0] fb [$];
        fb = '{u, FUNC_READ, st[15:8], st[7:0], cnt[15:8], cnt[7:0]};
        add_frame(fb, good_crc);
    endtask

    // random message: mostly well-formed frames, some noise and broken headers
    task automatic add_random_message();
        logic [7:0] fb [$];
        int sel;
        int n;
        logic [15:0] st;
        sel = $urandom_range(0, 99);
        st = base_reg + $urandom_range(0, 8);
        if ($urandom_range(0, 9) == 0)
            st = $urandom;
        if (sel < 50)
            add_read(($urandom_range(0, 7) == 0) ? 8'($urandom) : unit_addr, st,
                     $urandom_range(0, 9), $urandom_range(0, 9) != 0);
        else if (sel < 62)
        begin
            fb = '{unit_addr, 8'($urandom)};
            n = $urandom_range(0, 4);
            for (int k = 0; k < n; k++)
                fb.push_back($urandom);
            add_frame(fb, 1'b1);
        end
        else if (sel < 70)
            add_closed();
        else if (sel < 78)
            add_sample($urandom_range(0, 7), $urandom);
        else if (sel < 88)
        begin
            // header broken at a random spot
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
                pending_items.push_back(msg_byte(ipd_byte(k), k == 0));
            pending_items.push_back(msg_byte($urandom, 1'b0));
        end
        else
        begin
            n = $urandom_range(1, 5);
            for (int k = 0; k < n; k++)
                pending_items.push_back(msg_byte($urandom, $urandom_range(0, 1)));
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SLAVE: unit_addr = val[7:0];
            CFG_FIRST: base_reg = val;
            CFG_MAXC:  count_limit = val[6:0];
            default: ;
        endcase
    endtask

    // waits until every item is accepted and every result has been taken
    task automatic drain();
        wait (pending_items.size() == 0 && !push && expected_bytes.size() == 0 && empty);
        repeat (8) @(posedge clk);
    endtask

    // ---------------- driver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            request <= '0;
        end
        else
        begin
            if (push && !full)
                model_item(request);
            if (!(push && full))
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle)
                begin
                    request <= pending_items.pop_front();
                    push <= 1'b1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $realtime, result);
                    failed = 1'b1;
                end
                else
                begin
                    result_t e;
                    e = expected_bytes.pop_front();
                    if (e.event_kind != result.event_kind)
                    begin
                        $display("%0t: event_kind expected %0d actual %0d", $realtime,
                                 e.event_kind, result.event_kind);
                        failed = 1'b1;
                    end
                    if (e.tx_byte != result.tx_byte)
                    begin
                        $display("%0t: tx_byte expected %h actual %h", $realtime,
                                 e.tx_byte, result.tx_byte);
                        failed = 1'b1;
                    end
                    if (e.last_byte != result.last_byte)
                    begin
                        $display("%0t: last_byte expected %0d actual %0d", $realtime,
                                 e.last_byte, result.last_byte);
                        failed = 1'b1;
                    end
                end
            end
            pop <= ($urandom_range(0, 99) >= receiver_idle);
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || stim_done)
            wdog <= 0;
        else if (wdog >= WDOG_MAX)
        begin
            $display("FAIL modbus_read_registers_responder_core");
            $finish;
        end
        else
            wdog <= wdog + 1;
    end

    // ---------------- test sequence ----------------
    initial
    begin
        logic [7:0] fb [$];
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SLAVE;
        cfg_data = '0;
        failed = 1'b0;
        stim_done = 1'b0;
        wdog = 0;
        sender_idle = 21;
        receiver_idle = 50;
        unit_addr = SLAVE_RST;
        base_reg = FIRST_RST;
        count_limit = MAXC_RST;
        hdr_pos = '0;
        phase = PH_IDLE;
        decl_len = '0;
        byte_pos = '0;
        crc_acc = 16'hFFFF;
        f_unit = '0;
        f_func = '0;
        f_start = '0;
        f_count = '0;
        rx_crc = '0;
        foreach (samples[i])
            samples[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset defaults, read all channels while still zero
        add_read(SLAVE_RST, FIRST_RST, CH_N, 1'b1);
        add_sample(3'd0, 8'hFF);
        add_sample(3'd6, 8'h00);
        add_sample(3'd7, 8'hAA);           // channel past the store, ignored
        add_sample(3'd3, 8'h5A);
        add_read(SLAVE_RST, FIRST_RST, CH_N, 1'b1);
        add_read(SLAVE_RST, FIRST_RST, 16'd0, 1'b1);   // count zero
        add_read(SLAVE_RST, FIRST_RST + 6, 16'd2, 1'b1); // past last channel
        add_read(SLAVE_RST, FIRST_RST - 1, 16'd1, 1'b1); // below base
        add_read(SLAVE_RST, FIRST_RST, 16'd1, 1'b0);   // bad CRC
        add_read(8'd9, FIRST_RST, 16'd1, 1'b1);        // foreign unit
        fb = '{SLAVE_RST, 8'h10};
        add_frame(fb, 1'b1);                           // unsupported function
        fb = '{SLAVE_RST, FUNC_READ};
        add_frame(fb, 1'b1);                           // short read frame
        add_closed();
        drain();

        // extremes of the configuration
        write_reg(CFG_SLAVE, 16'd247);
        write_reg(CFG_FIRST, 16'd0);
        write_reg(CFG_MAXC, 16'd1);
        add_read(8'd247, 16'd0, 16'd1, 1'b1);
        add_read(8'd247, 16'd0, 16'd2, 1'b1);          // over max count
        // sample mid-frame, new message aborting a frame, oversize length
        add_read(8'd247, 16'd6, 16'd1, 1'b1);
        pending_items.insert(pending_items.size() - 3, '{1'b1, 8'h00, 1'b0, 3'd6, 8'h77});
        for (int k = 0; k < 7; k++)
            pending_items.push_back(msg_byte(ipd_byte(k), k == 0));
        pending_items.push_back(msg_byte("9", 1'b0));
        pending_items.push_back(msg_byte(":", 1'b0));
        pending_items.push_back(msg_byte(8'd247, 1'b0));
        add_closed();
        for (int k = 0; k < 7; k++)
            pending_items.push_back(msg_byte(ipd_byte(k), k == 0));
        for (int k = 0; k < 5; k++)
            pending_items.push_back(msg_byte("9", 1'b0));  // saturates
        pending_items.push_back(msg_byte(":", 1'b0));
        for (int k = 0; k < 7; k++)
            pending_items.push_back(msg_byte(ipd_byte(k), k == 0));
        pending_items.push_back(msg_byte(":", 1'b0));   // no digits
        add_closed();
        drain();

        write_reg(CFG_FIRST, 16'd65535);
        write_reg(CFG_MAXC, 16'd125);
        add_read(8'd247, 16'd65535, 16'd1, 1'b1);
        drain();

        // random phases over several settings and idling schemes
        for (int ph = 0; ph < 3; ph++)
        begin
            sender_idle = (ph == 0) ? 21 : (ph == 1) ? 50 : 0;
            receiver_idle = (ph == 0) ? 50 : (ph == 1) ? 21 : 0;
            write_reg(CFG_SLAVE, $urandom_range(1, 247));
            write_reg(CFG_FIRST, $urandom_range(0, 65535));
            write_reg(CFG_MAXC, $urandom_range(1, 8));
            for (int m = 0; m < 2; m++)
                add_random_message();
            drain();
        end

        stim_done = 1'b1;
        if (failed || expected_bytes.size() != 0)
            $display("FAIL modbus_read_registers_responder_core");
        else
            $display("PASS modbus_read_registers_responder_core");
        $finish;
    end

endmodule
